// ===== src/assert_macros.svh =====
// assertion macros for the joystick axis conditioner
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMP(lbl, ck, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NXT(lbl, ck, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMP(lbl, ck, rstn, ante, cons, msg)

`define ASSERT_NXT(lbl, ck, rstn, ante, cons, msg)

`endif

`endif

// ===== src/jac_pkg.sv =====
// shared types and constants for the joystick axis conditioner
`default_nettype none

package jac_pkg;

    localparam int DATA_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [DATA_W-1:0] DEADZONE_RESET = 16'd100;
    localparam logic [DATA_W-1:0] SCALE_RESET    = 16'd128;

    localparam int MOTION_MAX = 32767;
    localparam int MOTION_MIN = -32768;

    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEADZONE = 2'd0,
        CFG_SCALE    = 2'd1,
        CFG_INV_X    = 2'd2,
        CFG_INV_Y    = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [DATA_W-1:0] deadzone;
        logic [DATA_W-1:0] scale;
        logic              inv_x;
        logic              inv_y;
    } cfg_t;

    typedef enum logic {
        ENTRY_CENTER = 1'b0,
        ENTRY_RUN    = 1'b1
    } entry_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_PREP   = 3'd1,
        ST_DZ     = 3'd2,
        ST_DIV    = 3'd3,
        ST_POST   = 3'd4,
        ST_EMIT_X = 3'd5,
        ST_EMIT_Y = 3'd6
    } back_state_t;

endpackage

`default_nettype wire

// ===== src/jac_queue.sv =====
// short fifo between the front and back ends
`default_nettype none

module jac_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = mem_reg[rd_ptr_reg];
    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);

endmodule

`default_nettype wire

// ===== src/jac_front.sv =====
// front end: accepts sample pairs, runs calibration sums, queues work
`default_nettype none

module jac_front #(
    parameter int CAL_SAMPLES = 8,
    parameter int SAMPLE_BITS = 13,
    parameter int SUM_W       = 17
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] raw_x,
    input  wire logic signed [SAMPLE_BITS-1:0] raw_y,
    input  wire logic                    q_full,
    output logic                         push,
    output jac_pkg::entry_kind_t         push_kind,
    output logic signed [SUM_W-1:0]      push_a,
    output logic signed [SUM_W-1:0]      push_b
);

    localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
    localparam logic [CNT_W-1:0] CAL_CNT  = CNT_W'(CAL_SAMPLES);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(CAL_SAMPLES - 1);

    logic [CNT_W-1:0]        calib_count_reg, calib_count_next;
    logic signed [SUM_W-1:0] sum_x_reg, sum_x_next;
    logic signed [SUM_W-1:0] sum_y_reg, sum_y_next;
    logic signed [SUM_W-1:0] ext_x, ext_y;
    logic                    accept;
    logic                    calibrating;

    assign ext_x       = {{(SUM_W - SAMPLE_BITS){raw_x[SAMPLE_BITS-1]}}, raw_x};
    assign ext_y       = {{(SUM_W - SAMPLE_BITS){raw_y[SAMPLE_BITS-1]}}, raw_y};
    assign in_ready    = !q_full;
    assign accept      = in_valid && in_ready;
    assign calibrating = (calib_count_reg != CAL_CNT);

    always_comb
    begin
        calib_count_next = calib_count_reg;
        sum_x_next       = sum_x_reg;
        sum_y_next       = sum_y_reg;
        if (accept && calibrating)
        begin
            calib_count_next = calib_count_reg + 1'b1;
            sum_x_next       = sum_x_reg + ext_x;
            sum_y_next       = sum_y_reg + ext_y;
        end
        push      = accept && (!calibrating || calib_count_reg == LAST_CNT);
        push_kind = calibrating ? jac_pkg::ENTRY_CENTER : jac_pkg::ENTRY_RUN;
        push_a    = calibrating ? sum_x_next : ext_x;
        push_b    = calibrating ? sum_y_next : ext_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calib_count_reg <= '0;
            sum_x_reg       <= '0;
            sum_y_reg       <= '0;
        end
        else
        begin
            calib_count_reg <= calib_count_next;
            sum_x_reg       <= sum_x_next;
            sum_y_reg       <= sum_y_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/jac_div.sv =====
// bit-serial restoring unsigned divider, one quotient bit per cycle
`default_nettype none

module jac_div #(
    parameter int DW = 17
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [DW-1:0]              dividend,
    input  wire logic [jac_pkg::DATA_W-1:0] divisor,
    output logic                            done,
    output logic [DW-1:0]                   quotient
);

    localparam int RW    = jac_pkg::DATA_W + 1;
    localparam int CNT_W = $clog2(DW + 1);
    localparam logic [CNT_W-1:0] STEPS = CNT_W'(DW);

    logic [RW-1:0]              rem_reg, rem_next;
    logic [DW-1:0]              quo_reg, quo_next;
    logic [jac_pkg::DATA_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       done_reg, done_next;
    logic [RW-1:0]              shifted;
    logic [RW-1:0]              dvs_ext;
    logic                       ge;

    assign shifted = {rem_reg[RW-2:0], quo_reg[DW-1]};
    assign dvs_ext = {1'b0, dvs_reg};
    assign ge      = (shifted >= dvs_ext);

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
            cnt_next = STEPS;
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = ge ? (shifted - dvs_ext) : shifted;
            quo_next  = {quo_reg[DW-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== src/jac_back.sv =====
// back end: center, deadzone, scale, saturate and emit results
`default_nettype none

module jac_back #(
    parameter int CAL_SAMPLES = 8,
    parameter int SAMPLE_BITS = 13,
    parameter int SUM_W       = 17
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire jac_pkg::cfg_t              cfg,
    input  wire logic                       q_empty,
    output logic                            pop,
    input  wire jac_pkg::entry_kind_t       entry_kind,
    input  wire logic signed [SUM_W-1:0]    entry_a,
    input  wire logic signed [SUM_W-1:0]    entry_b,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic                            axis,
    output logic signed [jac_pkg::DATA_W-1:0] motion,
    output logic                            sync
);

    localparam int DW  = SUM_W;
    localparam int BW  = (DW > jac_pkg::DATA_W) ? DW : jac_pkg::DATA_W;
    localparam int CW  = BW + 1;
    localparam int VW  = BW + 2;
    localparam logic signed [VW-1:0] SAT_HI = VW'(jac_pkg::MOTION_MAX);
    localparam logic signed [VW-1:0] SAT_LO = VW'(jac_pkg::MOTION_MIN);
    localparam logic [jac_pkg::DATA_W-1:0] CAL_DIV = jac_pkg::DATA_W'(CAL_SAMPLES);

    jac_pkg::back_state_t state_reg, state_next;

    jac_pkg::entry_kind_t        kind_reg, kind_next;
    logic signed [SUM_W-1:0]     a_reg, a_next;
    logic signed [SUM_W-1:0]     b_reg, b_next;
    logic signed [SAMPLE_BITS-1:0] center_x_reg, center_x_next;
    logic signed [SAMPLE_BITS-1:0] center_y_reg, center_y_next;
    logic [DW-1:0]               mag_x_reg, mag_x_next;
    logic [DW-1:0]               mag_y_reg, mag_y_next;
    logic                        neg_x_reg, neg_x_next;
    logic                        neg_y_reg, neg_y_next;
    logic [jac_pkg::DATA_W-1:0]  dx_reg, dx_next;
    logic [jac_pkg::DATA_W-1:0]  dy_reg, dy_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        axis_reg, axis_next;
    logic [jac_pkg::DATA_W-1:0]  motion_reg, motion_next;
    logic                        sync_reg, sync_next;

    logic signed [SUM_W-1:0]     off_x, off_y;
    logic [DW-1:0]               vmag_x, vmag_y;
    logic [DW-1:0]               dvd_x, dvd_y;
    logic [jac_pkg::DATA_W-1:0]  dvs;
    logic                        div_start;
    logic                        div_x_done, div_y_done;
    logic [DW-1:0]               quo_x, quo_y;
    logic signed [VW-1:0]        val_x, val_y;
    logic                        load_ok;

    function automatic logic signed [SUM_W-1:0] center_ext(
        input logic signed [SAMPLE_BITS-1:0] c
    );
        return {{(SUM_W - SAMPLE_BITS){c[SAMPLE_BITS-1]}}, c};
    endfunction

    function automatic logic [DW-1:0] magnitude(input logic signed [SUM_W-1:0] v);
        return v[SUM_W-1] ? DW'(-v) : DW'(v);
    endfunction

    function automatic logic [DW-1:0] deadzone(
        input logic [DW-1:0]              m,
        input logic [jac_pkg::DATA_W-1:0] dz
    );
        logic [CW-1:0] m_ext;
        logic [CW-1:0] dz_ext;
        logic [CW-1:0] diff;
        m_ext  = {{(CW - DW){1'b0}}, m};
        dz_ext = {{(CW - jac_pkg::DATA_W){1'b0}}, dz};
        diff   = m_ext - dz_ext;
        return (m_ext > dz_ext) ? diff[DW-1:0] : '0;
    endfunction

    function automatic logic signed [VW-1:0] apply_sign(
        input logic [DW-1:0] q,
        input logic          neg
    );
        logic signed [VW-1:0] q_ext;
        q_ext = {{(VW - DW){1'b0}}, q};
        return neg ? -q_ext : q_ext;
    endfunction

    function automatic logic [jac_pkg::DATA_W-1:0] saturate(input logic signed [VW-1:0] v);
        logic signed [VW-1:0] c;
        priority if (v > SAT_HI)
        begin
            c = SAT_HI;
        end
        else if (v < SAT_LO)
        begin
            c = SAT_LO;
        end
        else
        begin
            c = v;
        end
        return c[jac_pkg::DATA_W-1:0];
    endfunction

    assign off_x  = (kind_reg == jac_pkg::ENTRY_RUN) ? a_reg - center_ext(center_x_reg) : a_reg;
    assign off_y  = (kind_reg == jac_pkg::ENTRY_RUN) ? b_reg - center_ext(center_y_reg) : b_reg;
    assign vmag_x = deadzone(mag_x_reg, cfg.deadzone);
    assign vmag_y = deadzone(mag_y_reg, cfg.deadzone);
    assign dvd_x  = (kind_reg == jac_pkg::ENTRY_RUN) ? vmag_x : mag_x_reg;
    assign dvd_y  = (kind_reg == jac_pkg::ENTRY_RUN) ? vmag_y : mag_y_reg;
    assign dvs    = (kind_reg == jac_pkg::ENTRY_CENTER) ? CAL_DIV :
                    (cfg.scale == '0) ? jac_pkg::DATA_W'(1) : cfg.scale;
    assign val_x  = apply_sign(quo_x, neg_x_reg);
    assign val_y  = apply_sign(quo_y, neg_y_reg);
    assign load_ok = !out_valid_reg || out_ready;

    jac_div #(
        .DW (DW)
    ) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd_x),
        .divisor  (dvs),
        .done     (div_x_done),
        .quotient (quo_x)
    );

    jac_div #(
        .DW (DW)
    ) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd_y),
        .divisor  (dvs),
        .done     (div_y_done),
        .quotient (quo_y)
    );

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        center_x_next  = center_x_reg;
        center_y_next  = center_y_reg;
        mag_x_next     = mag_x_reg;
        mag_y_next     = mag_y_reg;
        neg_x_next     = neg_x_reg;
        neg_y_next     = neg_y_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        axis_next      = axis_reg;
        motion_next    = motion_reg;
        sync_next      = sync_reg;
        out_valid_next = out_valid_reg && !out_ready;
        pop            = 1'b0;
        div_start      = 1'b0;
        unique case (state_reg)
            jac_pkg::ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    kind_next  = entry_kind;
                    a_next     = entry_a;
                    b_next     = entry_b;
                    state_next = jac_pkg::ST_PREP;
                end
            end
            jac_pkg::ST_PREP:
            begin
                mag_x_next = magnitude(off_x);
                mag_y_next = magnitude(off_y);
                neg_x_next = off_x[SUM_W-1];
                neg_y_next = off_y[SUM_W-1];
                state_next = jac_pkg::ST_DZ;
            end
            jac_pkg::ST_DZ:
            begin
                div_start = 1'b1;
                if (kind_reg == jac_pkg::ENTRY_RUN)
                begin
                    neg_x_next = neg_x_reg ^ cfg.inv_x;
                    neg_y_next = neg_y_reg ^ cfg.inv_y;
                end
                state_next = jac_pkg::ST_DIV;
            end
            jac_pkg::ST_DIV:
            begin
                if (div_x_done && div_y_done)
                begin
                    state_next = jac_pkg::ST_POST;
                end
            end
            jac_pkg::ST_POST:
            begin
                if (kind_reg == jac_pkg::ENTRY_CENTER)
                begin
                    center_x_next = val_x[SAMPLE_BITS-1:0];
                    center_y_next = val_y[SAMPLE_BITS-1:0];
                    state_next    = jac_pkg::ST_IDLE;
                end
                else
                begin
                    dx_next    = saturate(val_x);
                    dy_next    = saturate(val_y);
                    state_next = jac_pkg::ST_EMIT_X;
                end
            end
            jac_pkg::ST_EMIT_X:
            begin
                if (dx_reg == '0)
                begin
                    state_next = jac_pkg::ST_EMIT_Y;
                end
                else if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    axis_next      = jac_pkg::AXIS_X;
                    motion_next    = dx_reg;
                    sync_next      = (dy_reg == '0);
                    state_next     = jac_pkg::ST_EMIT_Y;
                end
            end
            jac_pkg::ST_EMIT_Y:
            begin
                if (dy_reg == '0)
                begin
                    state_next = jac_pkg::ST_IDLE;
                end
                else if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    axis_next      = jac_pkg::AXIS_Y;
                    motion_next    = dy_reg;
                    sync_next      = 1'b1;
                    state_next     = jac_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = jac_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= jac_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            center_x_reg  <= '0;
            center_y_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            center_x_reg  <= center_x_next;
            center_y_reg  <= center_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        mag_x_reg  <= mag_x_next;
        mag_y_reg  <= mag_y_next;
        neg_x_reg  <= neg_x_next;
        neg_y_reg  <= neg_y_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        axis_reg   <= axis_next;
        motion_reg <= motion_next;
        sync_reg   <= sync_next;
    end

    assign out_valid = out_valid_reg;
    assign axis      = axis_reg;
    assign motion    = motion_reg;
    assign sync      = sync_reg;

endmodule

`default_nettype wire

// ===== src/joystick_axis_conditioner_core.sv =====
// top level of the joystick axis conditioner
// The block takes X/Y ADC sample pairs. The first CAL_SAMPLES pairs after reset are summed
// and set the per-axis centers; later pairs are centered, put through the deadzone, divided
// by the scale register (0 acts as 1), optionally negated and saturated, and give up to two
// results, X first, the last one marked by sync. The front end takes calibration pairs at
// one per cycle and queues work into a two-entry fifo, so up to two pairs can wait while
// the back end is busy; in_ready drops while the fifo is full. The back end takes one
// queued pair at a time through PREP, DZ, DIV and POST and, after calibration, EMIT_X and
// EMIT_Y, which wait on out_ready. SUM_W = SAMPLE_BITS + clog2(CAL_SAMPLES) + 1 is the width
// of the sums; DIV waits on the two bit-serial dividers, one per axis, which take one
// quotient bit per cycle. Register writes are taken every cycle.
`default_nettype none

`include "assert_macros.svh"

module joystick_axis_conditioner_core #(
    parameter int CAL_SAMPLES = 8,
    parameter int SAMPLE_BITS = 13
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [jac_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [jac_pkg::DATA_W-1:0]      cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]   raw_x,
    input  wire logic signed [SAMPLE_BITS-1:0]   raw_y,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 axis,
    output logic signed [jac_pkg::DATA_W-1:0]    motion,
    output logic                                 sync
);

    localparam int SUM_W       = SAMPLE_BITS + $clog2(CAL_SAMPLES) + 1;
    localparam int QW          = 2 * SUM_W + 1;
    localparam int QUEUE_DEPTH = 2;

    jac_pkg::cfg_t cfg_reg, cfg_next;

    logic                    push, pop, q_full, q_empty;
    jac_pkg::entry_kind_t    push_kind;
    logic signed [SUM_W-1:0] push_a, push_b;
    logic [QW-1:0]           q_wr_data, q_rd_data;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (jac_pkg::cfg_idx_t'(cfg_index))
                jac_pkg::CFG_DEADZONE: cfg_next.deadzone = cfg_data;
                jac_pkg::CFG_SCALE:    cfg_next.scale    = cfg_data;
                jac_pkg::CFG_INV_X:    cfg_next.inv_x    = cfg_data[0];
                jac_pkg::CFG_INV_Y:    cfg_next.inv_y    = cfg_data[0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.deadzone <= jac_pkg::DEADZONE_RESET;
            cfg_reg.scale    <= jac_pkg::SCALE_RESET;
            cfg_reg.inv_x    <= 1'b0;
            cfg_reg.inv_y    <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    jac_front #(
        .CAL_SAMPLES (CAL_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .raw_x     (raw_x),
        .raw_y     (raw_y),
        .q_full    (q_full),
        .push      (push),
        .push_kind (push_kind),
        .push_a    (push_a),
        .push_b    (push_b)
    );

    assign q_wr_data = {push_kind, push_a, push_b};

    jac_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (q_wr_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (q_rd_data),
        .empty     (q_empty)
    );

    jac_back #(
        .CAL_SAMPLES (CAL_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_empty    (q_empty),
        .pop        (pop),
        .entry_kind (jac_pkg::entry_kind_t'(q_rd_data[QW-1])),
        .entry_a    (q_rd_data[2*SUM_W-1:SUM_W]),
        .entry_b    (q_rd_data[SUM_W-1:0]),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .axis       (axis),
        .motion     (motion),
        .sync       (sync)
    );

    `ASSERT_IMP(a_no_zero_motion, clk, rst_n, out_valid, motion != '0, "zero motion emitted")
    `ASSERT_IMP(a_y_is_last, clk, rst_n, out_valid && axis, sync, "y result without sync")
    `ASSERT_IMP(a_no_overflow, clk, rst_n, push, !q_full || pop, "push into full queue")
    `ASSERT_NXT(a_pop_spacing, clk, rst_n, pop, !pop, "back end popped twice in a row")

endmodule

`default_nettype wire
